// ===== sv/kqss_pkg.sv =====
// kqss_pkg: shared types and constants for the k-queue shared store
// no dependencies; compiled first

package kqss_pkg;

  localparam int QUEUE_ID_W = 2;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;

  typedef enum logic [0:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

// ===== sv/kqss_in_if.sv =====
// kqss_in_if: operation channel (valid/ready plus operation payload)
// depends on kqss_pkg

interface kqss_in_if;
  import kqss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [0:0]               func;
  logic [QUEUE_ID_W-1:0]    queue_id;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, func, queue_id, data_in, input ready);
  modport sink   (input valid, func, queue_id, data_in, output ready);

endinterface

// ===== sv/kqss_out_if.sv =====
// kqss_out_if: result channel (valid/ready plus result payload)
// depends on kqss_pkg

interface kqss_out_if;
  import kqss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, data_out, status, input ready);
  modport sink   (input valid, data_out, status, output ready);

endinterface

// ===== sv/kqss_ram.sv =====
// kqss_ram: generic single write port, single read port ram with registered read
// no dependencies

module kqss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/k_queues_shared_store_top.sv =====
// k_queues_shared_store_top: several fifo queues sharing one slot store with a free list
// depends on kqss_pkg, kqss_in_if, kqss_out_if, kqss_ram
//
// usage:
//   in_i carries one operation per transfer: func (enqueue or dequeue), queue_id and
//   data_in. out_o returns exactly one result per operation, in order: data_out (the
//   dequeued value, zero otherwise) and status (ok, full on enqueue, empty on dequeue).
//   an operation on a queue number not below QUEUES changes nothing and reports
//   full or empty like a failed enqueue or dequeue.
// timing:
//   the link and data rams are read at the input transfer; the operation is then held in
//   the stage registers, resolved against the pointer tables and written into the result
//   register once that register is free. one operation per cycle is sustained while
//   results are taken, set by the single read port of the link ram, with bypasses from
//   the operation ahead covering back-to-back use of the same slot.
// reset:
//   all queues empty, every slot on the free list in order; the link ram needs no
//   clearing pass, slots never handed out are tracked by a fill count.
// stall:
//   while the result register holds an untaken result, one more operation is taken
//   and held; the input then waits until the result transfers.

module k_queues_shared_store_top #(
  parameter int ENTRIES = 16,
  parameter int QUEUES  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  kqss_in_if.sink         in_i,
  kqss_out_if.source      out_o
);
  import kqss_pkg::*;

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  // stage registers
  logic                     s1_v_q;
  logic [0:0]               s1_func_q;
  logic [QUEUE_ID_W-1:0]    s1_qid_q;
  logic signed [DATA_W-1:0] s1_din_q;
  logic                     use_pre_q, use_pre_d;
  logic [PW-1:0]            pre_q, pre_d;
  logic                     dbyp_q, dbyp_d;
  logic signed [DATA_W-1:0] dbyp_dat_q;

  // pointer state
  logic [PW-1:0] head_q [QUEUES];
  logic [PW-1:0] head_d [QUEUES];
  logic [PW-1:0] tail_q [QUEUES];
  logic [PW-1:0] tail_d [QUEUES];
  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] fill_q, fill_d;

  // result register
  logic                     out_v_q;
  logic signed [DATA_W-1:0] out_dout_q;
  logic [STATUS_W-1:0]      out_status_q;

  logic                     s1_go;
  logic                     in_fire;
  logic [QW-1:0]            s1_qi;
  logic                     s1_qok;
  logic [PW-1:0]            hd;
  logic [PW-1:0]            tl;
  logic                     hd_ok;
  logic [PW-1:0]            nh;
  logic [PW-1:0]            link_val;
  logic signed [DATA_W-1:0] data_val;
  logic [PW-1:0]            link_rdata;
  logic [DATA_W-1:0]        data_rdata;

  logic                     lw_en;
  logic [PW-1:0]            lw_addr;
  logic [PW-1:0]            lw_data;
  logic                     dw_en;
  logic [PW-1:0]            dw_addr;

  logic signed [DATA_W-1:0] res_dout;
  status_e                  res_status;

  logic [QW-1:0]            qx;
  logic [PW-1:0]            raddr;

  assign s1_go    = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s1_go;
  assign in_fire  = in_i.valid && in_i.ready;

  assign s1_qi    = QW'(s1_qid_q);
  assign s1_qok   = (32'(s1_qid_q) < 32'(QUEUES));
  assign hd       = head_q[s1_qi];
  assign tl       = tail_q[s1_qi];
  assign hd_ok    = s1_qok && (hd < NIL);
  assign link_val = use_pre_q ? pre_q : link_rdata;
  assign data_val = dbyp_q ? dbyp_dat_q : signed'(data_rdata);
  assign nh       = (hd == tl) ? NIL : link_val;

  // operation resolve and table update
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    free_head_d = free_head_q;
    fill_d      = fill_q;
    lw_en       = 1'b0;
    lw_addr     = '0;
    lw_data     = '0;
    dw_en       = 1'b0;
    dw_addr     = free_head_q;
    res_dout    = '0;
    res_status  = STATUS_OK;
    if (s1_func_q == FUNC_ENQ) begin
      if (!(s1_qok && (free_head_q < NIL))) begin
        res_status = STATUS_FULL;
      end else if (s1_go) begin
        free_head_d = link_val;
        if (hd < NIL) begin
          lw_en   = 1'b1;
          lw_addr = tl;
          lw_data = free_head_q;
        end else begin
          head_d[s1_qi] = free_head_q;
        end
        tail_d[s1_qi] = free_head_q;
        dw_en         = 1'b1;
        if (free_head_q == fill_q) begin
          fill_d = fill_q + PW'(1);
        end
      end
    end else begin
      if (!hd_ok) begin
        res_status = STATUS_EMPTY;
      end else begin
        res_dout = data_val;
        if (s1_go) begin
          head_d[s1_qi] = nh;
          if (nh == NIL) begin
            tail_d[s1_qi] = NIL;
          end
          lw_en       = 1'b1;
          lw_addr     = hd;
          lw_data     = free_head_q;
          free_head_d = hd;
        end
      end
    end
  end

  // read address for the incoming operation, against the state left by the one ahead
  assign qx    = QW'(in_i.queue_id);
  assign raddr = (in_i.func == FUNC_DEQ) ? head_d[qx] : free_head_d;

  always_comb begin
    use_pre_d = 1'b0;
    pre_d     = raddr + PW'(1);
    dbyp_d    = dw_en && (dw_addr == raddr);
    if (lw_en && (lw_addr == raddr)) begin
      use_pre_d = 1'b1;
      pre_d     = lw_data;
    end else if (raddr >= fill_d) begin
      use_pre_d = 1'b1;
    end
  end

  kqss_ram #(
    .WIDTH (PW),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en),
    .waddr_i (lw_addr[IW-1:0]),
    .wdata_i (lw_data),
    .re_i    (in_fire),
    .raddr_i (raddr[IW-1:0]),
    .rdata_o (link_rdata)
  );

  kqss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dw_en),
    .waddr_i (dw_addr[IW-1:0]),
    .wdata_i (s1_din_q),
    .re_i    (in_fire),
    .raddr_i (raddr[IW-1:0]),
    .rdata_o (data_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      free_head_q <= '0;
      fill_q      <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
    end else begin
      if (in_fire) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        out_v_q     <= 1'b1;
        head_q      <= head_d;
        tail_q      <= tail_d;
        free_head_q <= free_head_d;
        fill_q      <= fill_d;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q  <= in_i.func;
      s1_qid_q   <= in_i.queue_id;
      s1_din_q   <= in_i.data_in;
      use_pre_q  <= use_pre_d;
      pre_q      <= pre_d;
      dbyp_q     <= dbyp_d;
      dbyp_dat_q <= s1_din_q;
    end
    if (s1_go) begin
      out_dout_q   <= res_dout;
      out_status_q <= res_status;
    end
  end

  assign out_o.valid    = out_v_q;
  assign out_o.data_out = out_dout_q;
  assign out_o.status   = out_status_q;

endmodule

// ===== tb/sv/tb_k_queues_shared_store_top.sv =====
// tb_k_queues_shared_store_top: self-checking bench for the k-queue shared store
// drives random enqueue/dequeue transfers, predicts each result, checks the result channel
// depends on kqss_pkg, kqss_in_if, kqss_out_if and the k_queues_shared_store_top rtl

module tb_k_queues_shared_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kqss_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int QUEUES    = 4;
  localparam int PTR_W     = 5;
  localparam int IDX_W     = 4;
  localparam int RAND_OPS  = 1200;
  localparam int HOLD_AT   = 400;
  localparam int HOLD_LEN  = 150;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

  typedef struct packed {
    func_e                    func;
    logic [QUEUE_ID_W-1:0]    qid;
    logic signed [DATA_W-1:0] data;
  } store_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    status_e                  status;
  } store_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     drv_valid = 1'b0;
  logic [0:0]               drv_func  = FUNC_ENQ;
  logic [QUEUE_ID_W-1:0]    drv_qid   = '0;
  logic signed [DATA_W-1:0] drv_data  = '0;
  logic                     rx_ready  = 1'b0;

  kqss_in_if  in_ch ();
  kqss_out_if out_ch ();

  assign in_ch.valid    = drv_valid;
  assign in_ch.func     = drv_func;
  assign in_ch.queue_id = drv_qid;
  assign in_ch.data_in  = drv_data;
  assign out_ch.ready   = rx_ready;

  k_queues_shared_store_top #(
    .ENTRIES (ENTRIES),
    .QUEUES  (QUEUES)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [PTR_W-1:0]         head_ptr  [QUEUES];
  logic [PTR_W-1:0]         tail_ptr  [QUEUES];
  logic [PTR_W-1:0]         link_tbl  [ENTRIES];
  logic signed [DATA_W-1:0] slot_data [ENTRIES];
  logic [PTR_W-1:0]         free_head;

  store_op_t  op_queue [$];
  store_res_t due_results [$];
  store_op_t  next_op;
  store_res_t due;
  int         ops_total;
  int         ops_sent;
  int         err_cnt = 0;
  int         burst_left;
  int         gap_left;
  int         rx_cycle;
  int         hold_left;
  bit         hold_done;

  function automatic store_res_t queue_op_result(store_op_t op);
    store_res_t       r;
    logic [PTR_W-1:0] slot;
    r.data_out = '0;
    r.status   = STATUS_OK;
    if (int'(op.qid) >= QUEUES) begin
      r.status = (op.func == FUNC_ENQ) ? STATUS_FULL : STATUS_EMPTY;
    end else if (op.func == FUNC_ENQ) begin
      slot = free_head;
      if (slot >= ENTRIES) begin
        r.status = STATUS_FULL;
      end else begin
        free_head = link_tbl[slot[IDX_W-1:0]];
        if (head_ptr[op.qid] >= ENTRIES) begin
          head_ptr[op.qid] = slot;
        end else if (tail_ptr[op.qid] < ENTRIES) begin
          link_tbl[tail_ptr[op.qid][IDX_W-1:0]] = slot;
        end
        link_tbl[slot[IDX_W-1:0]]  = NIL;
        tail_ptr[op.qid]           = slot;
        slot_data[slot[IDX_W-1:0]] = op.data;
      end
    end else begin
      slot = head_ptr[op.qid];
      if (slot >= ENTRIES) begin
        r.status = STATUS_EMPTY;
      end else begin
        head_ptr[op.qid] = link_tbl[slot[IDX_W-1:0]];
        if (head_ptr[op.qid] >= ENTRIES) tail_ptr[op.qid] = NIL;
        link_tbl[slot[IDX_W-1:0]] = free_head;
        free_head                 = slot;
        r.data_out                = slot_data[slot[IDX_W-1:0]];
      end
    end
    return r;
  endfunction

  task automatic add_op(func_e f, int q, logic signed [DATA_W-1:0] d);
    store_op_t op;
    op.func = f;
    op.qid  = QUEUE_ID_W'(q);
    op.data = d;
    op_queue.push_back(op);
  endtask

  // sender: bursts of transfers with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      drv_valid  <= 1'b0;
      drv_func   <= FUNC_ENQ;
      drv_qid    <= '0;
      drv_data   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
      ops_sent   <= 0;
    end else begin
      if (drv_valid && in_ch.ready) ops_sent <= ops_sent + 1;
      if (!drv_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left  <= gap_left - 1;
          drv_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          next_op = op_queue.pop_front();
          drv_func  <= next_op.func;
          drv_qid   <= next_op.qid;
          drv_data  <= next_op.data;
          drv_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_ready  <= 1'b0;
      rx_cycle  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (!hold_done && ops_sent >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        rx_ready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rx_ready  <= 1'b0;
      end else begin
        case ((rx_cycle / 256) % 3)
          0: rx_ready <= 1'b1;
          1: rx_ready <= ($urandom_range(0, 3) != 0);
          default: rx_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: predict on input transfer, check on result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUES; i++) begin
        head_ptr[i] = NIL;
        tail_ptr[i] = NIL;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        link_tbl[i]  = PTR_W'(i + 1);
        slot_data[i] = '0;
      end
      link_tbl[ENTRIES-1] = NIL;
      free_head = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(queue_op_result({func_e'(in_ch.func), in_ch.queue_id,
                                               in_ch.data_in}));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: data_out %0d status %0d", $time,
                   out_ch.data_out, out_ch.status);
          err_cnt++;
        end else begin
          due = due_results.pop_front();
          if (out_ch.data_out !== due.data_out) begin
            $display("%0t: data_out expected %0d got %0d", $time, due.data_out,
                     out_ch.data_out);
            err_cnt++;
          end
          if (out_ch.status !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time, due.status,
                     out_ch.status);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int bias;
    int chunk;
    int n;
    // empty queue, field extremes, fill to full, drain a little
    add_op(FUNC_DEQ, 0, 0);
    add_op(FUNC_ENQ, 0, 32'sh8000_0000);
    add_op(FUNC_ENQ, 1, 32'sh7fff_ffff);
    add_op(FUNC_ENQ, 2, 32'sh0000_0000);
    add_op(FUNC_ENQ, 3, -32'sd1);
    for (int i = 0; i < ENTRIES - 4; i++) add_op(FUNC_ENQ, i % QUEUES, $urandom);
    add_op(FUNC_ENQ, 2, $urandom);
    for (int q = 0; q < QUEUES; q++) add_op(FUNC_DEQ, q, $urandom);
    add_op(FUNC_DEQ, 3, 0);
    add_op(FUNC_ENQ, 3, $urandom);
    // random phases that lean toward filling or draining the store
    n = 0;
    while (n < RAND_OPS) begin
      chunk = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0: bias = 80;
        1: bias = 50;
        default: bias = 20;
      endcase
      for (int i = 0; i < chunk && n < RAND_OPS; i++) begin
        add_op(($urandom_range(0, 99) < bias) ? FUNC_ENQ : FUNC_DEQ,
               $urandom_range(0, QUEUES - 1), $urandom);
        n++;
      end
    end
    ops_total = op_queue.size();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (ops_sent < ops_total || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_k_queues_shared_store_top: done, clean");
    end else begin
      $display("tb_k_queues_shared_store_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_k_queues_shared_store_top: done, errors");
    $finish;
  end

endmodule
